[rtl/mte_pkg.sv]
package mte_pkg;

    localparam int HISTORY_DEPTH = 8192;
    localparam int SAMPLE_BITS   = 16;
    localparam int ADDR_BITS     = $clog2(HISTORY_DEPTH);
    localparam int DELAY_BITS    = 12;
    localparam int DELAY_MAX     = 2048;
    localparam int TAP_BITS      = DELAY_BITS + 2;
    localparam int CMP_BITS      = (TAP_BITS > ADDR_BITS) ? TAP_BITS : ADDR_BITS;
    localparam int GAIN_BITS     = 16;
    localparam int PROD_BITS     = SAMPLE_BITS + GAIN_BITS + 1;
    localparam int ACC_BITS      = SAMPLE_BITS + GAIN_BITS + 3;
    localparam int WIDE_BITS     = ACC_BITS - GAIN_BITS;
    localparam int CFG_DATA_BITS = DELAY_BITS;

    localparam logic [1:0] STRENGTH_FEEDBACK = 2'd1;
    localparam logic [1:0] STRENGTH_THREE    = 2'd3;
    localparam logic [1:0] STRENGTH_RESET    = 2'd2;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(2000);

    localparam logic [0:0] REG_ECHO_STRENGTH = 1'b0;
    localparam logic [0:0] REG_BASE_DELAY    = 1'b1;

    localparam logic [GAIN_BITS-1:0] GAIN_065 = GAIN_BITS'(42598);
    localparam logic [GAIN_BITS-1:0] GAIN_050 = GAIN_BITS'(32768);
    localparam logic [GAIN_BITS-1:0] GAIN_035 = GAIN_BITS'(22938);

    localparam logic [1:0] SLOT_NONE = 2'd0;
    localparam logic [1:0] SLOT_1    = 2'd1;
    localparam logic [1:0] SLOT_2    = 2'd2;
    localparam logic [1:0] SLOT_3    = 2'd3;

    // A gain of zero marks a tap that the current strength does not use.
    function automatic logic [GAIN_BITS-1:0] tap_gain(input logic [1:0] strength,
                                                      input logic [1:0] slot);
        logic [GAIN_BITS-1:0] gain;
        gain = '0;
        case (strength)
            STRENGTH_FEEDBACK: begin
                if (slot == SLOT_2) gain = GAIN_050;
            end
            STRENGTH_THREE: begin
                case (slot)
                    SLOT_1:  gain = GAIN_065;
                    SLOT_2:  gain = GAIN_050;
                    SLOT_3:  gain = GAIN_035;
                    default: gain = '0;
                endcase
            end
            default: begin
                case (slot)
                    SLOT_1:  gain = GAIN_050;
                    SLOT_2:  gain = GAIN_035;
                    default: gain = '0;
                endcase
            end
        endcase
        return gain;
    endfunction

endpackage

[rtl/multi_tap_echo_unit.sv]
// Multi-tap echo on a stream of signed audio samples, one result per request.
// Input channel: s_valid/s_ready with s_sample_in and s_record_start; a set
// record_start restarts the history count so that no tap counts for that sample.
// Result channel: m_valid/m_ready with m_sample_out, saturated to 16 bits.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_addr (0 strength,
// 1 base delay) at once; write only while no request is in flight.
// The engine has four steps per request, one for each of up to three
// reads of the single history memory and one to round, saturate and write back.
// The result reaches m_valid through the output register, loaded in write-back.
// Sustained throughput is set by the shared memory read port, which the tap
// reads take in turn; a one-entry input buffer takes the next request meanwhile.
// When the receiver stalls, the finished result waits in the output register
// and the engine holds in its write-back step until the register frees.
// Reset clears the counters and restores strength 2 and delay 2000; the history
// memory is not cleared, since only entries written in the current record count.
module multi_tap_echo_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [mte_pkg::SAMPLE_BITS-1:0] s_sample_in,
    input  logic                                 s_record_start,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [mte_pkg::SAMPLE_BITS-1:0] m_sample_out,
    input  logic                                 cfg_wr_en,
    input  logic [0:0]                           cfg_addr,
    input  logic [mte_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

    localparam int SB = mte_pkg::SAMPLE_BITS;
    localparam int AB = mte_pkg::ADDR_BITS;
    localparam int TB = mte_pkg::TAP_BITS;
    localparam int CB = mte_pkg::CMP_BITS;
    localparam int GB = mte_pkg::GAIN_BITS;
    localparam int PB = mte_pkg::PROD_BITS;
    localparam int XB = mte_pkg::ACC_BITS;
    localparam int WB = mte_pkg::WIDE_BITS;

    localparam logic signed [WB-1:0] Y_MAX = WB'(2 ** (SB - 1) - 1);
    localparam logic signed [WB-1:0] Y_MIN = -Y_MAX - WB'(1);
    localparam logic [AB-1:0] SEEN_MAX = AB'(mte_pkg::HISTORY_DEPTH - 1);
    localparam logic [XB-1:0] ROUND_BIAS = XB'(2 ** (GB - 1));
    localparam logic [TB-1:0] DELAY_CAP = TB'(mte_pkg::DELAY_MAX);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_TAP1 = 5'b00010,
        ST_TAP2 = 5'b00100,
        ST_TAP3 = 5'b01000,
        ST_WBK  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [1:0]                        strength_reg;
    logic [mte_pkg::DELAY_BITS-1:0]    delay_reg;

    logic                              buf_valid_reg;
    logic signed [SB-1:0]              buf_sample_reg;
    logic                              buf_start_reg;

    logic signed [SB-1:0]              x_reg;
    logic signed [XB-1:0]              acc_reg;
    logic [AB-1:0]                     seen_reg, seen_next;
    logic [AB-1:0]                     wp_reg;

    logic signed [SB-1:0]              mem [mte_pkg::HISTORY_DEPTH];
    logic signed [SB-1:0]              rdata_reg;
    logic [AB-1:0]                     raddr;
    logic                              mem_we;
    logic signed [SB-1:0]              mem_wdata;

    logic                              out_valid_reg;
    logic signed [SB-1:0]              out_sample_reg;

    logic                              advance_wb;
    logic                              start;
    logic [TB-1:0]                     d1, d2, d3, d_cur;
    logic [1:0]                        slot;
    logic [GB-1:0]                     gain_cur;
    logic                              tap_used;
    logic signed [GB:0]                gain_s;
    logic signed [PB-1:0]              product;
    logic signed [XB-1:0]              term;
    logic signed [XB-1:0]              acc_sum;
    logic signed [XB-1:0]              acc_init;
    logic signed [WB-1:0]              y_wide;
    logic signed [SB-1:0]              y_sat;

    assign s_ready      = !buf_valid_reg;
    assign m_valid      = out_valid_reg;
    assign m_sample_out = out_sample_reg;

    assign advance_wb = (state_reg == ST_WBK) && (!out_valid_reg || m_ready);
    assign start      = buf_valid_reg && ((state_reg == ST_IDLE) || advance_wb);

    always_comb begin
        if (delay_reg == '0) begin
            d1 = TB'(1);
        end else if (TB'(delay_reg) > DELAY_CAP) begin
            d1 = DELAY_CAP;
        end else begin
            d1 = TB'(delay_reg);
        end
        d2 = d1 << 1;
        d3 = d1 + d2;
    end

    always_comb begin
        unique case (state_reg)
            ST_IDLE: state_next = start ? ST_TAP1 : ST_IDLE;
            ST_TAP1: state_next = ST_TAP2;
            ST_TAP2: state_next = ST_TAP3;
            ST_TAP3: state_next = ST_WBK;
            ST_WBK: begin
                if (advance_wb) begin
                    state_next = start ? ST_TAP1 : ST_IDLE;
                end else begin
                    state_next = ST_WBK;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Read data is registered and arrives in the step after its address, so each step adds the tap read before it.
    always_comb begin
        case (state_reg)
            ST_TAP1: raddr = wp_reg - AB'(d1);
            ST_TAP2: raddr = wp_reg - AB'(d2);
            default: raddr = wp_reg - AB'(d3);
        endcase
        case (state_reg)
            ST_TAP2: begin
                slot  = mte_pkg::SLOT_1;
                d_cur = d1;
            end
            ST_TAP3: begin
                slot  = mte_pkg::SLOT_2;
                d_cur = d2;
            end
            ST_WBK: begin
                slot  = mte_pkg::SLOT_3;
                d_cur = d3;
            end
            default: begin
                slot  = mte_pkg::SLOT_NONE;
                d_cur = d3;
            end
        endcase
    end

    always_comb begin
        gain_cur = mte_pkg::tap_gain(strength_reg, slot);
        tap_used = (gain_cur != '0) && (CB'(d_cur) <= CB'(seen_reg));
        gain_s   = signed'({1'b0, gain_cur});
        product  = gain_s * rdata_reg;
        term     = tap_used ? XB'(product) : '0;
        acc_sum  = acc_reg + term;
        acc_init = (XB'(buf_sample_reg) <<< GB) + signed'(ROUND_BIAS);
        y_wide   = signed'(acc_sum[XB-1:GB]);
        if (y_wide > Y_MAX) begin
            y_sat = SB'(Y_MAX);
        end else if (y_wide < Y_MIN) begin
            y_sat = SB'(Y_MIN);
        end else begin
            y_sat = SB'(y_wide);
        end
        mem_we    = advance_wb;
        mem_wdata = (strength_reg == mte_pkg::STRENGTH_FEEDBACK) ? y_sat : x_reg;
    end

    always_comb begin
        seen_next = seen_reg;
        if (advance_wb && (seen_reg < SEEN_MAX)) begin
            seen_next = seen_reg + AB'(1);
        end
        if (start && buf_start_reg) begin
            seen_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wp_reg] <= mem_wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            strength_reg  <= mte_pkg::STRENGTH_RESET;
            delay_reg     <= mte_pkg::DELAY_RESET;
            buf_valid_reg <= 1'b0;
            seen_reg      <= '0;
            wp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    mte_pkg::REG_ECHO_STRENGTH: strength_reg <= cfg_wdata[1:0];
                    mte_pkg::REG_BASE_DELAY:    delay_reg    <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                buf_valid_reg <= 1'b1;
            end else if (start) begin
                buf_valid_reg <= 1'b0;
            end
            if (advance_wb) begin
                wp_reg        <= wp_reg + AB'(1);
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            buf_sample_reg <= s_sample_in;
            buf_start_reg  <= s_record_start;
        end
        if (start) begin
            x_reg   <= buf_sample_reg;
            acc_reg <= acc_init;
        end else if ((state_reg == ST_TAP2) || (state_reg == ST_TAP3)) begin
            acc_reg <= acc_sum;
        end
        if (advance_wb) begin
            out_sample_reg <= y_sat;
        end
    end

`ifndef NO_ASSERTIONS
    a_result_from_wb: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg == ST_WBK))
        else $error("result appeared without a write-back step");

    a_wp_step: assert property (@(posedge aclk) disable iff (!aresetn)
        advance_wb |=> wp_reg == $past(wp_reg) + AB'(1))
        else $error("write pointer did not advance by one");

    a_wp_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance_wb |=> $stable(wp_reg))
        else $error("write pointer moved outside write-back");

    a_record_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TAP1) && x_reg == x_reg && $past(start && buf_start_reg)
        |-> seen_reg == '0)
        else $error("history count not cleared at record start");
`endif

endmodule
